[src/cais_pkg.sv]
// Package with shared types and constants for the comment-aware identifier scan.
`default_nettype none
package cais_pkg;

  localparam int MaxNameChars = 8;
  localparam int QueueDepth   = 4;
  localparam int QPtrW        = $clog2(QueueDepth);
  localparam int QCntW        = $clog2(QueueDepth + 1);
  localparam int NameCharsW   = 8 * MaxNameChars;
  localparam int NameLenW     = 4;
  localparam int CfgIndexW    = 1;

  localparam logic [CfgIndexW-1:0] CFG_NAME_CHARS  = 1'd0;
  localparam logic [CfgIndexW-1:0] CFG_NAME_LENGTH = 1'd1;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

  typedef enum logic [3:0] {
    CLS_OTHER,
    CLS_SLASH,
    CLS_STAR,
    CLS_AT,
    CLS_BSLASH,
    CLS_DQUOTE,
    CLS_SQUOTE,
    CLS_NL,
    CLS_CR,
    CLS_IDENT,
    CLS_DIGIT
  } byte_class_t;

  typedef enum logic [2:0] {
    LEX_NORMAL,
    LEX_BLOCK,
    LEX_AT,
    LEX_STRING,
    LEX_CHAR,
    LEX_LINE
  } lex_state_t;

  typedef enum logic [1:0] {
    TOK_NONE,
    TOK_END,
    TOK_ADD
  } tok_act_t;

  typedef struct packed {
    logic [7:0]  text_byte;
    logic        last_byte;
    byte_class_t cls;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

endpackage
`default_nettype wire

[src/cais_front.sv]
// Front end: accepts text words and classifies each byte for the lexer.
`default_nettype none
module cais_front (
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_text_byte,
  input  wire logic               in_last_byte,
  input  wire logic               q_full,
  output logic                    q_push,
  output cais_pkg::q_entry_t      q_wdata
);
  import cais_pkg::*;

  byte_class_t cls;

  always_comb begin
    if (in_text_byte == CH_SLASH) begin
      cls = CLS_SLASH;
    end else if (in_text_byte == CH_STAR) begin
      cls = CLS_STAR;
    end else if (in_text_byte == CH_AT) begin
      cls = CLS_AT;
    end else if (in_text_byte == CH_BSLASH) begin
      cls = CLS_BSLASH;
    end else if (in_text_byte == CH_DQUOTE) begin
      cls = CLS_DQUOTE;
    end else if (in_text_byte == CH_SQUOTE) begin
      cls = CLS_SQUOTE;
    end else if (in_text_byte == CH_NL) begin
      cls = CLS_NL;
    end else if (in_text_byte == CH_CR) begin
      cls = CLS_CR;
    end else if ((in_text_byte >= 8'h41 && in_text_byte <= 8'h5A) ||
                 (in_text_byte >= 8'h61 && in_text_byte <= 8'h7A) ||
                 in_text_byte == CH_UNDER) begin
      cls = CLS_IDENT;
    end else if (in_text_byte >= 8'h30 && in_text_byte <= 8'h39) begin
      cls = CLS_DIGIT;
    end else begin
      cls = CLS_OTHER;
    end
  end

  assign in_ready          = !q_full;
  assign q_push            = in_valid && !q_full;
  assign q_wdata.text_byte = in_text_byte;
  assign q_wdata.last_byte = in_last_byte;
  assign q_wdata.cls       = cls;

endmodule
`default_nettype wire

[src/cais_queue.sv]
// Short queue of classified bytes between the front end and the lexer.
`default_nettype none
module cais_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire cais_pkg::q_entry_t wdata,
  output logic                    full,
  input  wire logic               pop,
  output cais_pkg::q_head_t       head
);
  import cais_pkg::*;

  q_entry_t               mem_r [QueueDepth];
  logic [QPtrW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0]       count_r, count_nxt;

  assign full        = count_r == QCntW'(QueueDepth);
  assign head.valid  = count_r != '0;
  assign head.entry  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

[src/cais_back.sv]
// Back end: lexical state machine, token matcher, registers and result register.
`default_nettype none
module cais_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [cais_pkg::CfgIndexW-1:0]    cfg_index,
  input  wire logic [cais_pkg::NameCharsW-1:0]   cfg_wdata,
  input  wire cais_pkg::q_head_t                 head,
  output logic                                   pop,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_found
);
  import cais_pkg::*;

  logic [NameCharsW-1:0] name_chars_r;
  logic [NameLenW-1:0]   name_length_r;

  lex_state_t            lex_r, lex_nxt;
  logic                  pend_r, pend_nxt;
  logic [NameLenW-1:0]   mc_r, mc_nxt;
  logic                  mm_r, mm_nxt;
  logic                  open_r, open_nxt;
  logic                  seen_r, seen_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r, out_found_nxt;
  tok_act_t              act;

  q_entry_t              e;
  assign e = head.entry;

  assign pop = head.valid && (!head.entry.last_byte || !out_valid_r || out_ready);

  // Next lexical state and the token action for this byte.
  always_comb begin
    lex_nxt  = lex_r;
    pend_nxt = 1'b0;
    act      = TOK_NONE;
    case (lex_r)
      LEX_BLOCK: begin
        if (pend_r && e.cls == CLS_SLASH) begin
          lex_nxt = LEX_NORMAL;
        end else begin
          pend_nxt = e.cls == CLS_STAR;
        end
      end
      LEX_AT: begin
        if (pend_r && e.cls == CLS_SLASH) begin
          lex_nxt = LEX_NORMAL;
        end else begin
          pend_nxt = e.cls == CLS_AT;
        end
      end
      LEX_STRING: begin
        if (!pend_r) begin
          if (e.cls == CLS_BSLASH) begin
            pend_nxt = 1'b1;
          end else if (e.cls == CLS_DQUOTE) begin
            lex_nxt = LEX_NORMAL;
          end
        end
      end
      LEX_CHAR: begin
        if (!pend_r) begin
          if (e.cls == CLS_BSLASH) begin
            pend_nxt = 1'b1;
          end else if (e.cls == CLS_SQUOTE) begin
            lex_nxt = LEX_NORMAL;
          end
        end
      end
      LEX_LINE: begin
        if (!(pend_r && (e.cls == CLS_NL || e.cls == CLS_CR))) begin
          if (e.cls == CLS_BSLASH) begin
            pend_nxt = 1'b1;
          end else if (e.cls == CLS_NL) begin
            lex_nxt = LEX_NORMAL;
          end
        end
      end
      default: begin
        lex_nxt = LEX_NORMAL;
        if (pend_r && e.cls == CLS_STAR) begin
          lex_nxt = LEX_BLOCK;
        end else if (pend_r && e.cls == CLS_SLASH) begin
          lex_nxt = LEX_LINE;
        end else if (pend_r && e.cls == CLS_AT) begin
          lex_nxt = LEX_AT;
        end else if (e.cls == CLS_SLASH) begin
          act      = TOK_END;
          pend_nxt = 1'b1;
        end else if (e.cls == CLS_DQUOTE) begin
          act     = TOK_END;
          lex_nxt = LEX_STRING;
        end else if (e.cls == CLS_SQUOTE) begin
          act     = TOK_END;
          lex_nxt = LEX_CHAR;
        end else if (e.cls == CLS_IDENT || (open_r && e.cls == CLS_DIGIT)) begin
          act = TOK_ADD;
        end else begin
          act = TOK_END;
        end
      end
    endcase
  end

  // Token matcher and result.
  always_comb begin
    logic [NameLenW-1:0] mc0;
    logic                mm0;
    logic                open1;
    logic                seen1;
    logic                hit;
    mc0   = mc_r;
    mm0   = mm_r;
    open1 = open_r;
    seen1 = seen_r;
    hit   = 1'b0;
    case (act)
      TOK_END: begin
        hit   = open_r ? (!mm_r && mc_r == name_length_r) : (name_length_r == '0);
        seen1 = seen_r | hit;
        open1 = 1'b0;
        mc0   = '0;
        mm0   = 1'b0;
      end
      TOK_ADD: begin
        if (!open_r) begin
          mc0 = '0;
          mm0 = 1'b0;
        end
        open1 = 1'b1;
        if (!mm0) begin
          if (mc0 < name_length_r && mc0 < NameLenW'(MaxNameChars) &&
              name_chars_r[mc0[2:0]*8 +: 8] == e.text_byte) begin
            mc0 = mc0 + 1'b1;
          end else begin
            mm0 = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    out_valid_nxt = out_valid_r && !out_ready;
    out_found_nxt = out_found_r;
    mc_nxt   = mc0;
    mm_nxt   = mm0;
    open_nxt = open1;
    seen_nxt = seen1;
    if (e.last_byte) begin
      hit           = open1 ? (!mm0 && mc0 == name_length_r) : (name_length_r == '0);
      out_valid_nxt = 1'b1;
      out_found_nxt = seen1 | hit;
      mc_nxt        = '0;
      mm_nxt        = 1'b0;
      open_nxt      = 1'b0;
      seen_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lex_r       <= LEX_NORMAL;
      pend_r      <= 1'b0;
      mc_r        <= '0;
      mm_r        <= 1'b0;
      open_r      <= 1'b0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (pop) begin
      lex_r       <= e.last_byte ? LEX_NORMAL : lex_nxt;
      pend_r      <= e.last_byte ? 1'b0 : pend_nxt;
      mc_r        <= mc_nxt;
      mm_r        <= mm_nxt;
      open_r      <= open_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end else begin
      out_valid_r <= out_valid_r && !out_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && e.last_byte) begin
      out_found_r <= out_found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_chars_r  <= '0;
      name_length_r <= NameLenW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NAME_CHARS:  name_chars_r  <= cfg_wdata;
        CFG_NAME_LENGTH: name_length_r <= cfg_wdata[NameLenW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;

endmodule
`default_nettype wire

[src/comment_aware_identifier_scan_top.sv]
// Top level of the comment-aware identifier scan.
//
// The input channel takes one word per byte of source text, with a flag on
// the final byte. The output channel gives one word per text: found is 1 when
// the configured identifier occurred as a whole token in code, outside
// comments and string or character literals.
// Throughput is one byte per cycle unless a final byte waits for the
// output register. The front end classifies each byte and writes it into
// a four-entry queue; the back end pops one byte per cycle and updates
// the lexical state and the token matcher in that cycle. The result is
// registered in the output register when the back end pops the last byte.
// The result sits in an output register. While it waits, the back end keeps
// consuming non-final bytes; only a final byte waits for the register to be
// taken, and once the queue is full in_ready drops.
// Configuration is written through cfg_we, cfg_index and cfg_wdata while the
// block is idle. Synchronous reset empties the queue, clears the scan state
// and the output valid flag, sets name_chars to zero and name_length to one.
`default_nettype none
module comment_aware_identifier_scan_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [7:0]                      in_text_byte,
  input  wire logic                            in_last_byte,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_found,
  input  wire logic                            cfg_we,
  input  wire logic [cais_pkg::CfgIndexW-1:0]  cfg_index,
  input  wire logic [cais_pkg::NameCharsW-1:0] cfg_wdata
);
  import cais_pkg::*;

  logic     q_full;
  logic     q_push;
  logic     q_pop;
  q_entry_t q_wdata;
  q_head_t  q_head;

  cais_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_text_byte (in_text_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  cais_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .head  (q_head)
  );

  cais_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_found (out_found)
  );

endmodule
`default_nettype wire

[src/cais_checker.sv]
// Port-level checker for the comment-aware identifier scan, bound to the top level.
`default_nettype none
module cais_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_last_byte,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_found
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found))
    else $error("result word dropped or changed while stalled");

  a_reset_no_result: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present right after reset");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready right after reset");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) && !(in_valid && in_ready && in_last_byte) |=> !out_valid)
    else $error("result word appeared without a final byte");

endmodule

bind comment_aware_identifier_scan_top cais_checker u_cais_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_last_byte (in_last_byte),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_found    (out_found)
);
`default_nettype wire
